[hw/rtl/bfspl_pkg.sv]
// Shared constants and types for the binned free-space page lists.
package bfspl_pkg;

    localparam int PAGE_W       = 10;
    localparam int PAGE_SPACE   = 1 << PAGE_W;
    localparam int LINK_W       = 11;
    localparam int BYTES_W      = 16;
    localparam int NUM_W        = 20;
    localparam int BIN_W        = 3;
    localparam int BIN_COUNT    = 5;
    localparam int PAGES_DEFAULT = 1024;

    localparam logic [LINK_W-1:0]  NIL_LINK      = 11'h7FF;
    localparam logic [BYTES_W-1:0] USABLE_RESET  = 16'd4096;
    localparam logic [BIN_W-1:0]   DECILE_FIRST  = 3'd1;
    localparam logic [BIN_W-1:0]   DECILE_SAT    = 3'd5;
    localparam logic [BIN_W-1:0]   BIN_LAST      = 3'd4;
    localparam logic [BIN_W-1:0]   BIN_NONE      = 3'd0;

    localparam logic FUNC_PUT    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_LINKED   = 2'd0,
        ST_UNLINKED = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_ALREADY  = 2'd3
    } status_t;

endpackage

[hw/rtl/bfspl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfspl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/binned_free_space_page_lists.sv]
// Top level: five doubly linked page lists binned by free-space decile.
//
//  channel    | handshake              | payload
//  -----------+------------------------+-----------------------------------
//  config     | cfg_wr_en              | cfg_wr_data (usable_page_bytes)
//  request    | req_valid / req_stall  | func, page_number, free_bytes
//  response   | rsp_valid / rsp_stall  | status, bin, bin_head
//
//  A transaction runs from acceptance through the accepting state, the decile
//  compare loop with one shared add-and-compare per cycle, up to 3 link RAM
//  steps, and a final state that loads the response once the output is free.
//  After reset the link RAMs are swept to nil, one entry per cycle, over
//  min(PAGES, 1024) entries; req_stall stays high meanwhile.
//  req_stall is high whenever a transaction is in progress.
//  A finished response waits in the output register under rsp_stall.
module binned_free_space_page_lists
    import bfspl_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [BYTES_W-1:0] cfg_wr_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [0:0]         func,
    input  logic [PAGE_W-1:0]  page_number,
    input  logic [BYTES_W-1:0] free_bytes,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic [BIN_W-1:0]   bin,
    output logic [LINK_W-1:0]  bin_head
);

    localparam int DEPTH = (PAGES < PAGE_SPACE) ? PAGES : PAGE_SPACE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLEAR    = 9'b000000010,
        S_DIV      = 9'b000000100,
        S_PUT      = 9'b000001000,
        S_PUT_LINK = 9'b000010000,
        S_FETCH    = 9'b000100000,
        S_UNLINK   = 9'b001000000,
        S_CLEAN    = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    function automatic logic link_is_page(input logic [LINK_W-1:0] v);
        return int'(v) < DEPTH;
    endfunction

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [BYTES_W-1:0]  usable_reg;
    logic                func_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic [BIN_W-1:0]    k_reg, k_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [LINK_W-1:0]   link_reg, link_next;
    status_t             res_status_reg, res_status_next;
    logic [LINK_W-1:0]   heads_reg [BIN_COUNT];
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg;
    logic [BIN_W-1:0]    out_bin_reg;
    logic [LINK_W-1:0]   out_head_reg;

    logic                accept;
    logic                out_load;
    logic [BYTES_W-1:0]  div_eff;
    logic [NUM_W-1:0]    num_in;
    logic                in_range;
    logic [AW-1:0]       page_addr;
    logic [LINK_W-1:0]   page_link;
    logic [LINK_W-1:0]   head_cur;
    logic                heads_any;
    logic                heads_we;
    logic [LINK_W-1:0]   heads_wdata;

    logic                nx_we, pv_we, rd_en;
    logic [AW-1:0]       nx_wa, pv_wa;
    logic [LINK_W-1:0]   nx_wd, pv_wd;
    logic [LINK_W-1:0]   nx_rd, pv_rd;

    bfspl_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_next_ram (
        .clk     (clk),
        .wr_en   (nx_we),
        .wr_addr (nx_wa),
        .wr_data (nx_wd),
        .rd_en   (rd_en),
        .rd_addr (page_addr),
        .rd_data (nx_rd)
    );

    bfspl_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_prev_ram (
        .clk     (clk),
        .wr_en   (pv_we),
        .wr_addr (pv_wa),
        .wr_data (pv_wd),
        .rd_en   (rd_en),
        .rd_addr (page_addr),
        .rd_data (pv_rd)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_load  = !out_valid_reg || !rsp_stall;
    assign div_eff   = (usable_reg == '0) ? BYTES_W'(1) : usable_reg;
    assign num_in    = ({4'b0, free_bytes} << 3) + ({4'b0, free_bytes} << 1);
    assign in_range  = int'(page_reg) < PAGES;
    assign page_addr = page_reg[AW-1:0];
    assign page_link = {1'b0, page_reg};
    assign head_cur  = heads_reg[bin_reg];

    always_comb
    begin
        heads_any = 1'b0;
        for (int i = 0; i < BIN_COUNT; i++)
        begin
            if (heads_reg[i] == page_link)
            begin
                heads_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        bin_next        = bin_reg;
        link_next       = link_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        heads_we        = 1'b0;
        heads_wdata     = NIL_LINK;
        nx_we           = 1'b0;
        nx_wa           = page_addr;
        nx_wd           = NIL_LINK;
        pv_we           = 1'b0;
        pv_wa           = page_addr;
        pv_wd           = NIL_LINK;
        rd_en           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                nx_we = 1'b1;
                nx_wa = clr_cnt_reg;
                pv_we = 1'b1;
                pv_wa = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_next   = {4'b0, div_eff};
                    k_next     = DECILE_FIRST;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (num_reg >= acc_reg && k_reg != DECILE_SAT)
                begin
                    acc_next = acc_reg + {4'b0, div_eff};
                    k_next   = k_reg + BIN_W'(1);
                end
                else if ((num_reg < acc_reg && k_reg == DECILE_FIRST) || !in_range)
                begin
                    bin_next        = BIN_NONE;
                    res_status_next = ST_IGNORED;
                    state_next      = S_DONE;
                end
                else
                begin
                    bin_next   = (num_reg >= acc_reg) ? BIN_LAST : k_reg - BIN_W'(2);
                    state_next = (func_reg == FUNC_REMOVE) ? S_FETCH : S_PUT;
                end
            end
            S_PUT:
            begin
                nx_we       = 1'b1;
                nx_wd       = head_cur;
                pv_we       = 1'b1;
                heads_we    = 1'b1;
                heads_wdata = page_link;
                link_next   = head_cur;
                state_next  = S_PUT_LINK;
            end
            S_PUT_LINK:
            begin
                pv_we           = link_is_page(link_reg);
                pv_wa           = link_reg[AW-1:0];
                pv_wd           = page_link;
                res_status_next = ST_LINKED;
                state_next      = S_DONE;
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                if (pv_rd == NIL_LINK && nx_rd == NIL_LINK && !heads_any)
                begin
                    res_status_next = ST_ALREADY;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (pv_rd == NIL_LINK)
                    begin
                        heads_we    = 1'b1;
                        heads_wdata = nx_rd;
                    end
                    else
                    begin
                        nx_we = link_is_page(pv_rd);
                        nx_wa = pv_rd[AW-1:0];
                        nx_wd = nx_rd;
                    end
                    pv_we      = link_is_page(nx_rd);
                    pv_wa      = nx_rd[AW-1:0];
                    pv_wd      = pv_rd;
                    state_next = S_CLEAN;
                end
            end
            S_CLEAN:
            begin
                nx_we           = 1'b1;
                pv_we           = 1'b1;
                res_status_next = ST_UNLINKED;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            usable_reg     <= USABLE_RESET;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_IGNORED;
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                heads_reg[i] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            if (cfg_wr_en)
            begin
                usable_reg <= cfg_wr_data;
            end
            if (heads_we)
            begin
                heads_reg[bin_reg] <= heads_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        bin_reg  <= bin_next;
        link_reg <= link_next;
        if (accept)
        begin
            func_reg <= func[0];
            page_reg <= page_number;
            num_reg  <= num_in;
        end
        if (state_reg == S_DONE && out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bin_reg    <= bin_reg;
            out_head_reg   <= (res_status_reg == ST_IGNORED) ? NIL_LINK : head_cur;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign bin       = out_bin_reg;
    assign bin_head  = out_head_reg;

endmodule
